// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the barometer compensation unit
// Calibration register indexes and reset words, the reference temperatures
// used by the second-order correction, and the rated output ranges.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  // Calibration register indexes
  typedef enum logic [2:0] {
    CFG_SENS_C1   = 3'd0,
    CFG_OFFSET_C2 = 3'd1,
    CFG_SENS_TC3  = 3'd2,
    CFG_OFF_TC4   = 3'd3,
    CFG_TREF_C5   = 3'd4,
    CFG_TSLOPE_C6 = 3'd5
  } cfg_idx_e;

  localparam int CFG_IDX_W = 3;
  localparam int CAL_W     = 16;

  // Calibration words after reset
  localparam logic [CAL_W-1:0] C1_RST = 16'd40127;
  localparam logic [CAL_W-1:0] C2_RST = 16'd36924;
  localparam logic [CAL_W-1:0] C3_RST = 16'd23317;
  localparam logic [CAL_W-1:0] C4_RST = 16'd23282;
  localparam logic [CAL_W-1:0] C5_RST = 16'd33464;
  localparam logic [CAL_W-1:0] C6_RST = 16'd28312;

  // Temperature base (20.00 C) and offset from it to -15.00 C
  localparam int TEMP_BASE   = 2000;
  localparam int TEMP_VLOW   = -1500;
  localparam int VLOW_OFFSET = 3500;

  // Rated output ranges
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRESS_MIN = 1000;
  localparam int PRESS_MAX = 120000;

endpackage

`default_nettype wire

// ===== rtl/baro_pressure_temp_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit: second-order barometer compensation
// Turns raw 24-bit pressure and temperature conversions into temperature in
// hundredths of a degree and pressure in pascals, using six calibration words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one raw pressure and
//   temperature pair per item; output channel (out_valid_o / out_stall_i)
//   carries one result item per input item, in order.
//   Calibration words are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the unit is idle; indexes above five are ignored.
//   An accepted item passes through all ten registered stages before its result is presented.
//   Throughput is one item per cycle of the ten-stage pipeline while the receiver does not stall; the
//   wide pressure product is split into two partial products across stages.
//   A raw value of zero yields an all-zero result with sample_valid_o low.
//   When the receiver stalls while a result is presented, every stage
//   freezes and in_stall_o is raised; nothing is lost or repeated.
//   Reset empties the pipeline and reloads the factory calibration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // calibration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [bpc_pkg::CAL_W-1:0]            cfg_wdata_i,
  // input channel
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic [23:0]                          raw_pressure_i,
  input  wire logic [23:0]                          raw_temperature_i,
  // output channel
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic signed [14:0]                   temperature_centi_c_o,
  output      logic [16:0]                          pressure_pa_o,
  output      logic                                 sample_valid_o,
  output      logic                                 clamped_o
);

  localparam int NumStages = 10;

  // --------------------------------------------------------------------------
  // Calibration registers
  // --------------------------------------------------------------------------
  logic [bpc_pkg::CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= bpc_pkg::C1_RST;
      c2_q <= bpc_pkg::C2_RST;
      c3_q <= bpc_pkg::C3_RST;
      c4_q <= bpc_pkg::C4_RST;
      c5_q <= bpc_pkg::C5_RST;
      c6_q <= bpc_pkg::C6_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpc_pkg::CFG_SENS_C1:   c1_q <= cfg_wdata_i;
        bpc_pkg::CFG_OFFSET_C2: c2_q <= cfg_wdata_i;
        bpc_pkg::CFG_SENS_TC3:  c3_q <= cfg_wdata_i;
        bpc_pkg::CFG_OFF_TC4:   c4_q <= cfg_wdata_i;
        bpc_pkg::CFG_TREF_C5:   c5_q <= cfg_wdata_i;
        bpc_pkg::CFG_TSLOPE_C6: c6_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: freeze every stage while a result is held
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic                 adv;

  assign adv        = !(vld_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: temperature difference and sample check
  // --------------------------------------------------------------------------
  logic signed [24:0] s1_dt_d, s1_dt_q;
  logic        [23:0] s1_d1_q;
  logic               s1_ok_d, s1_ok_q;

  assign s1_dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, c5_q, 8'h00});
  assign s1_ok_d = (raw_pressure_i != '0) && (raw_temperature_i != '0);

  // --------------------------------------------------------------------------
  // Stage 2: first-order products of dT
  // --------------------------------------------------------------------------
  logic signed [41:0] s2_pt_d, s2_po_d, s2_ps_d;
  logic signed [41:0] s2_pt_q, s2_po_q, s2_ps_q;
  logic signed [49:0] s2_pdd_d, s2_pdd_q;
  logic        [23:0] s2_d1_q;
  logic               s2_ok_q;

  assign s2_pt_d  = s1_dt_q * $signed({1'b0, c6_q});
  assign s2_po_d  = s1_dt_q * $signed({1'b0, c4_q});
  assign s2_ps_d  = s1_dt_q * $signed({1'b0, c3_q});
  assign s2_pdd_d = s1_dt_q * s1_dt_q;

  // --------------------------------------------------------------------------
  // Stage 3: TEMP, OFF, SENS and T2, plus correction flags
  // --------------------------------------------------------------------------
  logic signed [17:0] s3_d_d, s3_d_q;
  logic signed [18:0] s3_temp1_d, s3_temp1_q;
  logic signed [18:0] s3_c_d, s3_c_q;
  logic signed [34:0] s3_off1_d, s3_off1_q;
  logic signed [33:0] s3_sens1_d, s3_sens1_q;
  logic        [16:0] s3_t2_q;
  logic               s3_lo_q, s3_vlo_d, s3_vlo_q;
  logic        [23:0] s3_d1_q;
  logic               s3_ok_q;

  // d = TEMP - 2000 is the scaled dT product itself
  assign s3_d_d     = s2_pt_q[40:23];
  assign s3_temp1_d = {s3_d_d[17], s3_d_d} + 19'(bpc_pkg::TEMP_BASE);
  assign s3_c_d     = {s3_d_d[17], s3_d_d} + 19'(bpc_pkg::VLOW_OFFSET);
  assign s3_vlo_d   = s3_temp1_d < 19'(bpc_pkg::TEMP_VLOW);
  assign s3_off1_d  = $signed({3'b000, c2_q, 16'h0000})
                    + $signed({s2_po_q[40], s2_po_q[40:7]});
  assign s3_sens1_d = $signed({3'b000, c1_q, 15'h0000})
                    + $signed({s2_ps_q[40], s2_ps_q[40:8]});

  // --------------------------------------------------------------------------
  // Stage 4: squares of the correction distances
  // --------------------------------------------------------------------------
  logic signed [35:0] s4_dsq_full;
  logic signed [37:0] s4_csq_full;
  logic        [34:0] s4_dsq_q, s4_csq_q;
  logic signed [18:0] s4_temp1_q;
  logic signed [34:0] s4_off1_q;
  logic signed [33:0] s4_sens1_q;
  logic        [16:0] s4_t2_q;
  logic               s4_lo_q, s4_vlo_q;
  logic        [23:0] s4_d1_q;
  logic               s4_ok_q;

  assign s4_dsq_full = s3_d_q * s3_d_q;
  assign s4_csq_full = s3_c_q * s3_c_q;

  // --------------------------------------------------------------------------
  // Stage 5: OFF2 and SENS2 by shift and add
  // --------------------------------------------------------------------------
  logic        [36:0] s5_d5;
  logic        [37:0] s5_c7, s5_c11;
  logic        [37:0] s5_off2_d, s5_off2_q;
  logic        [36:0] s5_sens2_d, s5_sens2_q;
  logic signed [18:0] s5_temp1_q;
  logic signed [34:0] s5_off1_q;
  logic signed [33:0] s5_sens1_q;
  logic        [16:0] s5_t2_q;
  logic        [23:0] s5_d1_q;
  logic               s5_ok_q;

  assign s5_d5  = {2'b00, s4_dsq_q} + {s4_dsq_q, 2'b00};
  assign s5_c7  = {s4_csq_q, 3'b000} - {3'b000, s4_csq_q};
  assign s5_c11 = {s4_csq_q, 3'b000} + {2'b00, s4_csq_q, 1'b0} + {3'b000, s4_csq_q};

  always_comb begin
    s5_off2_d  = '0;
    s5_sens2_d = '0;
    if (s4_lo_q) begin
      s5_off2_d  = {2'b00, s5_d5[36:1]} + (s4_vlo_q ? s5_c7 : '0);
      s5_sens2_d = {2'b00, s5_d5[36:2]} + (s4_vlo_q ? s5_c11[37:1] : '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: apply second-order terms
  // --------------------------------------------------------------------------
  logic signed [19:0] s6_temp_d, s6_temp_q;
  logic signed [39:0] s6_off_d, s6_off_q;
  logic signed [39:0] s6_sens_d, s6_sens_q;
  logic        [23:0] s6_d1_q;
  logic               s6_ok_q;

  // T2 only counts below 20.00 C; OFF2 and SENS2 are already zero above
  assign s6_temp_d = {s5_temp1_q[18], s5_temp1_q} - $signed({3'b000, s5_t2_q});
  assign s6_off_d  = {{5{s5_off1_q[34]}}, s5_off1_q} - $signed({2'b00, s5_off2_q});
  assign s6_sens_d = {{6{s5_sens1_q[33]}}, s5_sens1_q} - $signed({3'b000, s5_sens2_q});

  // --------------------------------------------------------------------------
  // Stage 7: split D1 * SENS into two partial products
  // --------------------------------------------------------------------------
  logic        [43:0] s7_mlo_d, s7_mlo_q;
  logic signed [44:0] s7_mhi_d, s7_mhi_q;
  logic signed [19:0] s7_temp_q;
  logic signed [39:0] s7_off_q;
  logic               s7_ok_q;

  assign s7_mlo_d = s6_d1_q * s6_sens_q[19:0];
  assign s7_mhi_d = $signed({1'b0, s6_d1_q}) * $signed(s6_sens_q[39:20]);

  // --------------------------------------------------------------------------
  // Stage 8: combine partial products
  // --------------------------------------------------------------------------
  logic signed [63:0] s8_prod_d, s8_prod_q;
  logic signed [19:0] s8_temp_q;
  logic signed [39:0] s8_off_q;
  logic               s8_ok_q;

  assign s8_prod_d = $signed({s7_mhi_q[43:0], 20'h00000}) + $signed({20'h00000, s7_mlo_q});

  // --------------------------------------------------------------------------
  // Stage 9: pressure before saturation
  // --------------------------------------------------------------------------
  logic signed [43:0] s9_q;
  logic signed [28:0] s9_pres_d, s9_pres_q;
  logic signed [19:0] s9_temp_q;
  logic               s9_ok_q;

  assign s9_q      = $signed({s8_prod_q[63], s8_prod_q[63:21]})
                   - $signed({{4{s8_off_q[39]}}, s8_off_q});
  assign s9_pres_d = s9_q[43:15];

  // --------------------------------------------------------------------------
  // Stage 10: saturate to rated range and drop invalid samples
  // --------------------------------------------------------------------------
  logic signed [19:0] out_temp_sat;
  logic signed [28:0] out_pres_sat;
  logic               out_clamp_d;
  logic signed [14:0] out_temp_d, out_temp_q;
  logic        [16:0] out_pres_d, out_pres_q;
  logic               out_clamp_q, out_ok_q;

  always_comb begin
    out_temp_sat = s9_temp_q;
    out_pres_sat = s9_pres_q;
    out_clamp_d  = 1'b0;
    if (s9_temp_q < 20'(bpc_pkg::TEMP_MIN)) begin
      out_temp_sat = 20'(bpc_pkg::TEMP_MIN);
      out_clamp_d  = 1'b1;
    end
    if (s9_temp_q > 20'(bpc_pkg::TEMP_MAX)) begin
      out_temp_sat = 20'(bpc_pkg::TEMP_MAX);
      out_clamp_d  = 1'b1;
    end
    if (s9_pres_q < 29'(bpc_pkg::PRESS_MIN)) begin
      out_pres_sat = 29'(bpc_pkg::PRESS_MIN);
      out_clamp_d  = 1'b1;
    end
    if (s9_pres_q > 29'(bpc_pkg::PRESS_MAX)) begin
      out_pres_sat = 29'(bpc_pkg::PRESS_MAX);
      out_clamp_d  = 1'b1;
    end
    out_temp_d = out_temp_sat[14:0];
    out_pres_d = out_pres_sat[16:0];
    if (!s9_ok_q) begin
      out_temp_d  = '0;
      out_pres_d  = '0;
      out_clamp_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers: advance together, hold on stall
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      s1_dt_q    <= s1_dt_d;
      s1_d1_q    <= raw_pressure_i;
      s1_ok_q    <= s1_ok_d;
      // stage 2
      s2_pt_q    <= s2_pt_d;
      s2_po_q    <= s2_po_d;
      s2_ps_q    <= s2_ps_d;
      s2_pdd_q   <= s2_pdd_d;
      s2_d1_q    <= s1_d1_q;
      s2_ok_q    <= s1_ok_q;
      // stage 3
      s3_d_q     <= s3_d_d;
      s3_temp1_q <= s3_temp1_d;
      s3_c_q     <= s3_c_d;
      s3_off1_q  <= s3_off1_d;
      s3_sens1_q <= s3_sens1_d;
      s3_t2_q    <= s2_pdd_q[47:31];
      s3_lo_q    <= s3_d_d[17];
      s3_vlo_q   <= s3_vlo_d;
      s3_d1_q    <= s2_d1_q;
      s3_ok_q    <= s2_ok_q;
      // stage 4
      s4_dsq_q   <= s4_dsq_full[34:0];
      s4_csq_q   <= s4_csq_full[34:0];
      s4_temp1_q <= s3_temp1_q;
      s4_off1_q  <= s3_off1_q;
      s4_sens1_q <= s3_sens1_q;
      s4_t2_q    <= s3_lo_q ? s3_t2_q : '0;
      s4_lo_q    <= s3_lo_q;
      s4_vlo_q   <= s3_vlo_q;
      s4_d1_q    <= s3_d1_q;
      s4_ok_q    <= s3_ok_q;
      // stage 5
      s5_off2_q  <= s5_off2_d;
      s5_sens2_q <= s5_sens2_d;
      s5_temp1_q <= s4_temp1_q;
      s5_off1_q  <= s4_off1_q;
      s5_sens1_q <= s4_sens1_q;
      s5_t2_q    <= s4_t2_q;
      s5_d1_q    <= s4_d1_q;
      s5_ok_q    <= s4_ok_q;
      // stage 6
      s6_temp_q  <= s6_temp_d;
      s6_off_q   <= s6_off_d;
      s6_sens_q  <= s6_sens_d;
      s6_d1_q    <= s5_d1_q;
      s6_ok_q    <= s5_ok_q;
      // stage 7
      s7_mlo_q   <= s7_mlo_d;
      s7_mhi_q   <= s7_mhi_d;
      s7_temp_q  <= s6_temp_q;
      s7_off_q   <= s6_off_q;
      s7_ok_q    <= s6_ok_q;
      // stage 8
      s8_prod_q  <= s8_prod_d;
      s8_temp_q  <= s7_temp_q;
      s8_off_q   <= s7_off_q;
      s8_ok_q    <= s7_ok_q;
      // stage 9
      s9_pres_q  <= s9_pres_d;
      s9_temp_q  <= s8_temp_q;
      s9_ok_q    <= s8_ok_q;
      // stage 10
      out_temp_q  <= out_temp_d;
      out_pres_q  <= out_pres_d;
      out_clamp_q <= out_clamp_d;
      out_ok_q    <= s9_ok_q;
    end
  end

  // Drive the output channel
  assign out_valid_o           = vld_q[NumStages-1];
  assign temperature_centi_c_o = out_temp_q;
  assign pressure_pa_o         = out_pres_q;
  assign sample_valid_o        = out_ok_q;
  assign clamped_o             = out_clamp_q;

endmodule

`default_nettype wire

// ===== tb/bpc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_tb_pkg: scoreboard for the barometer compensation unit testbench
// Holds a bit-accurate copy of the second-order compensation and the
// calibration words, and a queue of expected readings that is checked
// against each result item leaving the unit.
// ----------------------------------------------------------------------------
package bpc_tb_pkg;

  import bpc_pkg::*;

  // One compensated reading as it leaves the unit
  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [16:0]        press_pa;
    logic               valid;
    logic               clamped;
  } reading_t;

  class comp_scoreboard;

    logic [CAL_W-1:0] cal [6];
    reading_t         expected_readings [$];
    int unsigned      mismatches;

    function new();
      cal = '{C1_RST, C2_RST, C3_RST, C4_RST, C5_RST, C6_RST};
      mismatches = 0;
    endfunction

    // Track a calibration write; indexes past the last word are dropped
    function void set_cal(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
      if (idx <= CFG_TSLOPE_C6) begin
        cal[idx] = val;
      end
    endfunction

    // Second-order compensation in 64-bit signed arithmetic
    function reading_t compensate(logic [23:0] raw_p, logic [23:0] raw_t);
      reading_t r;
      longint   d1, d2, c1, c2, c3, c4, c5, c6;
      longint   dt, temp, off, sens, pres, d, c, t2, off2, sens2;
      logic     sat;
      r = '0;
      if (raw_p == '0 || raw_t == '0) begin
        return r;
      end
      d1 = {40'd0, raw_p};
      d2 = {40'd0, raw_t};
      c1 = {48'd0, cal[CFG_SENS_C1]};
      c2 = {48'd0, cal[CFG_OFFSET_C2]};
      c3 = {48'd0, cal[CFG_SENS_TC3]};
      c4 = {48'd0, cal[CFG_OFF_TC4]};
      c5 = {48'd0, cal[CFG_TREF_C5]};
      c6 = {48'd0, cal[CFG_TSLOPE_C6]};

      // first-order terms
      dt   = d2 - (c5 <<< 8);
      temp = TEMP_BASE + ((dt * c6) >>> 23);
      off  = (c2 <<< 16) + ((c4 * dt) >>> 7);
      sens = (c1 <<< 15) + ((c3 * dt) >>> 8);

      // second-order correction below 20 C, extra term below -15 C
      if (temp < TEMP_BASE) begin
        d     = temp - TEMP_BASE;
        t2    = (dt * dt) >>> 31;
        off2  = (5 * d * d) >>> 1;
        sens2 = (5 * d * d) >>> 2;
        if (temp < TEMP_VLOW) begin
          c     = temp - TEMP_VLOW;
          off2  = off2 + 7 * c * c;
          sens2 = sens2 + ((11 * c * c) >>> 1);
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
      end

      pres = (((d1 * sens) >>> 21) - off) >>> 15;

      // saturate to the rated ranges
      sat = 1'b0;
      if (temp < TEMP_MIN) begin
        temp = TEMP_MIN;
        sat  = 1'b1;
      end
      if (temp > TEMP_MAX) begin
        temp = TEMP_MAX;
        sat  = 1'b1;
      end
      if (pres < PRESS_MIN) begin
        pres = PRESS_MIN;
        sat  = 1'b1;
      end
      if (pres > PRESS_MAX) begin
        pres = PRESS_MAX;
        sat  = 1'b1;
      end

      r.temp_centi = temp[14:0];
      r.press_pa   = pres[16:0];
      r.valid      = 1'b1;
      r.clamped    = sat;
      return r;
    endfunction

    // Queue the expected reading for an accepted input item
    function void note_sample(logic [23:0] raw_p, logic [23:0] raw_t);
      expected_readings.push_back(compensate(raw_p, raw_t));
    endfunction

    // Compare a result item with the oldest expected reading
    function void check_reading(reading_t got);
      reading_t exp_r;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result item: t=%0d p=%0d v=%0b c=%0b",
                   got.temp_centi, got.press_pa, got.valid, got.clamped);
        end
        return;
      end
      exp_r = expected_readings.pop_front();
      if (got.temp_centi !== exp_r.temp_centi || got.press_pa !== exp_r.press_pa ||
          got.valid !== exp_r.valid || got.clamped !== exp_r.clamped) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reading differs: exp t=%0d p=%0d v=%0b c=%0b, got t=%0d p=%0d v=%0b c=%0b",
                   exp_r.temp_centi, exp_r.press_pa, exp_r.valid, exp_r.clamped,
                   got.temp_centi, got.press_pa, got.valid, got.clamped);
        end
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

  endclass

endpackage

// ===== tb/tb_baro_pressure_temp_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation_unit: self-checking testbench
// Drives raw pressure/temperature pairs through the unit under several
// calibration sets and idle/stall patterns, and checks every result item
// against a bit-accurate compensation model kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;
  import bpc_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_SET = 206;
  localparam int DRAIN_CYCLES  = 24;

  logic                 clk_i;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i         = '0;
  logic [CAL_W-1:0]     cfg_wdata_i       = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_stall_o;
  logic [23:0]          raw_pressure_i    = '0;
  logic [23:0]          raw_temperature_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i       = 1'b0;
  logic signed [14:0]   temperature_centi_c_o;
  logic [16:0]          pressure_pa_o;
  logic                 sample_valid_o;
  logic                 clamped_o;

  comp_scoreboard sb = new();
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int unsigned    cycle_count = 0;

  baro_pressure_temp_compensation_unit uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .raw_pressure_i        (raw_pressure_i),
    .raw_temperature_i     (raw_temperature_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .temperature_centi_c_o (temperature_centi_c_o),
    .pressure_pa_o         (pressure_pa_o),
    .sample_valid_o        (sample_valid_o),
    .clamped_o             (clamped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("baro_pressure_temp_compensation_unit: mismatch");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Record accepted inputs and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_sample(raw_pressure_i, raw_temperature_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_reading('{temperature_centi_c_o, pressure_pa_o, sample_valid_o, clamped_o});
      end
    end
  end

  // Present one item and hold it until it is taken
  task automatic send_sample(input logic [23:0] raw_p, input logic [23:0] raw_t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= raw_p;
    raw_temperature_i <= raw_t;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // Write one calibration word; the caller drops the enable after a batch
  task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_cal(idx, val);
  endtask

  task automatic write_cal_set(input logic [CAL_W-1:0] w [6]);
    write_cal(CFG_SENS_C1,   w[0]);
    write_cal(CFG_OFFSET_C2, w[1]);
    write_cal(CFG_SENS_TC3,  w[2]);
    write_cal(CFG_OFF_TC4,   w[3]);
    write_cal(CFG_TREF_C5,   w[4]);
    write_cal(CFG_TSLOPE_C6, w[5]);
    // spare indexes must leave the words alone
    write_cal(CFG_IDX_SPARE6, CAL_W'($urandom_range(16'hFFFF)));
    write_cal(CFG_IDX_SPARE7, CAL_W'($urandom_range(16'hFFFF)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every expected reading has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Raw temperature that lands near a target, in hundredths of a degree
  function automatic logic [23:0] raw_temp_near(input int target);
    longint dt, slope, v;
    slope = {48'd0, sb.cal[CFG_TSLOPE_C6]};
    if (slope == 0) begin
      return 24'($urandom_range(1, 24'hFFFFFF));
    end
    dt = (longint'(target - TEMP_BASE) <<< 23) / slope;
    v  = ({48'd0, sb.cal[CFG_TREF_C5]} <<< 8) + dt + longint'(int'($urandom_range(600)) - 300);
    if (v < 1) v = 1;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[23:0];
  endfunction

  task automatic send_random_sample();
    int          kind;
    int          target;
    logic [23:0] raw_p;
    logic [23:0] raw_t;
    kind  = $urandom_range(99);
    raw_p = 24'($urandom_range(1, 24'hFFFFFF));
    raw_t = 24'($urandom_range(1, 24'hFFFFFF));
    if (kind < 8) begin
      // failed reads
      case ($urandom_range(2))
        0:       raw_p = '0;
        1:       raw_t = '0;
        default: begin
          raw_p = '0;
          raw_t = '0;
        end
      endcase
    end else if (kind < 30) begin
      // keep the fully random pair
    end else if (kind < 45) begin
      // hover around the range and correction thresholds
      case ($urandom_range(3))
        0:       target = TEMP_MIN;
        1:       target = TEMP_VLOW;
        2:       target = TEMP_BASE;
        default: target = TEMP_MAX;
      endcase
      raw_t = raw_temp_near(target + int'($urandom_range(200)) - 100);
    end else begin
      // plausible operating points
      raw_t = raw_temp_near(int'($urandom_range(14000)) - 5000);
      if ($urandom_range(9) < 7) begin
        raw_p = 24'($urandom_range(3000000, 11000000));
      end
    end
    send_sample(raw_p, raw_t);
  endtask

  // Main sequence
  initial begin
    logic [CAL_W-1:0] cal_set [6];
    int               set_num;
    int               i;
    int               pattern;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset calibration
    send_sample(24'd0, 24'd0);
    send_sample(24'd0, 24'd8569150);
    send_sample(24'd9085466, 24'd0);
    send_sample(24'd1, 24'd1);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'd1, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd1);
    send_sample(24'd9085466, 24'd8569150);
    send_sample(24'd9085466, {C5_RST, 8'd0});
    send_sample(24'd9085466, {C5_RST, 8'd0} - 24'd1);
    send_sample(24'd9085466, raw_temp_near(2500));
    send_sample(24'd9085466, raw_temp_near(0));
    send_sample(24'd9085466, raw_temp_near(-1600));
    send_sample(24'd9085466, raw_temp_near(-3950));
    send_sample(24'd9085466, raw_temp_near(-4300));
    send_sample(24'd9085466, raw_temp_near(8700));
    send_sample(24'd1000, 24'd8569150);
    send_sample(24'd16000000, 24'd8569150);
    send_sample(24'd3900000, raw_temp_near(2000));

    // Random items over several calibration sets
    for (set_num = 0; set_num < 5; set_num++) begin
      drain();
      case (set_num)
        0:       cal_set = '{C1_RST, C2_RST, C3_RST, C4_RST, C5_RST, C6_RST};
        1:       cal_set = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        2:       cal_set = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        3:       begin
          foreach (cal_set[k]) cal_set[k] = CAL_W'($urandom_range(16'hFFFF));
        end
        default: cal_set = '{16'd46372, 16'd43981, 16'd29059, 16'd27842,
                             16'd31553, 16'd28165};
      endcase
      write_cal_set(cal_set);
      for (i = 0; i < ITEMS_PER_SET; i++) begin
        // rotate through the idle/stall patterns in blocks of 40 items
        if (i % 40 == 0) begin
          pattern = (i / 40 + set_num) % 4;
          send_idle_pct  = (pattern == 1) ? 70 : (pattern == 3) ? 13 : 0;
          recv_stall_pct <= (pattern == 2) ? 70 : (pattern == 3) ? 13 : 0;
        end
        send_random_sample();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("baro_pressure_temp_compensation_unit: match");
    end else begin
      $display("baro_pressure_temp_compensation_unit: mismatch");
    end
    $finish;
  end

endmodule
